@@ hdl/frustum_box_point_cull_macros.svh @@
// Assertion helpers used by the checker file of the frustum cull block.
`ifndef FRUSTUM_BOX_POINT_CULL_MACROS_SVH
`define FRUSTUM_BOX_POINT_CULL_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while reset is high.
`define FBPC_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while reset is high.
`define FBPC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/fbpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fbpc_pkg;

   // Six frustum planes, one 64-bit register each, at byte address 8*i.
   localparam int NUM_PLANES     = 6;
   localparam int PLANE_IDX_BITS = 3;
   localparam int CSR_IDX_LSB    = 3;
   localparam int CSR_ADDR_BITS  = CSR_IDX_LSB + PLANE_IDX_BITS;
   localparam int CSR_DATA_BITS  = 64;

   typedef logic [PLANE_IDX_BITS-1:0] plane_idx_type;
   typedef logic [CSR_DATA_BITS-1:0]  plane_word_type;

   typedef enum logic {
      OP_BOX   = 1'b0,
      OP_POINT = 1'b1
   } op_type;

endpackage

`default_nettype wire

@@ hdl/frustum_box_point_cull.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Each accepted transfer passes through the input, product and result registers; rsp_valid
// marks its result for exactly one cycle.
// Throughput: one item per clock cycle; busy is low whenever reset is low.
// The receiver cannot stall, so no result is ever held back.
// Reset is synchronous and active high: it clears all six planes to zero, drops every item in
// flight and holds busy high while it lasts.
module frustum_box_point_cull #(
   parameter int COORD_BITS  = 22,
   parameter int NORMAL_BITS = 14
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,

   // Command channel
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire logic                                   req_operation,
   input  wire logic signed [COORD_BITS-1:0]           req_min_x,
   input  wire logic signed [COORD_BITS-1:0]           req_min_y,
   input  wire logic signed [COORD_BITS-1:0]           req_min_z,
   input  wire logic signed [COORD_BITS-1:0]           req_max_x,
   input  wire logic signed [COORD_BITS-1:0]           req_max_y,
   input  wire logic signed [COORD_BITS-1:0]           req_max_z,

   // Result channel
   output logic                                        rsp_valid,
   output logic                                        rsp_visible,

   // Plane register port
   input  wire logic                                   psel,
   input  wire logic                                   penable,
   input  wire logic                                   pwrite,
   input  wire logic [fbpc_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  wire logic [fbpc_pkg::CSR_DATA_BITS-1:0]     pwdata,
   output logic [fbpc_pkg::CSR_DATA_BITS-1:0]          prdata,
   output logic                                        pready
);

   import fbpc_pkg::*;

   // Normals carry NORMAL_BITS-2 fraction bits. The distance is shifted up by that much so
   // it lines up with the normal-times-coordinate products.
   localparam int NRM_FRAC  = NORMAL_BITS - 2;
   localparam int PROD_BITS = NORMAL_BITS + COORD_BITS;
   // Three exact products plus the aligned distance need two more bits than one product.
   localparam int SUM_BITS  = PROD_BITS + 2;
   // Bits of the distance that lie beyond the 64-bit register read as zero, so the register
   // is zero-extended to hold the whole packed plane before the distance is cut out.
   localparam int DIST_LSB  = 3 * NORMAL_BITS;
   localparam int PACK_BITS = (DIST_LSB + COORD_BITS > CSR_DATA_BITS) ?
                              (DIST_LSB + COORD_BITS) : CSR_DATA_BITS;

   // ------------------------------------------------------------------------------------
   // Plane registers. A write transfer completes when psel, penable, pwrite and pready are
   // all high. Address bits [5:3] select the plane; writes to the two unused slots are
   // dropped and those slots read as zero.
   // ------------------------------------------------------------------------------------
   plane_word_type plane_ff [NUM_PLANES];
   plane_word_type plane_in [NUM_PLANES];
   plane_idx_type  csr_idx;
   logic           csr_write;

   assign pready    = 1'b1;
   assign csr_idx   = paddr[CSR_IDX_LSB +: PLANE_IDX_BITS];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      prdata = '0;
      for (int p = 0; p < NUM_PLANES; p++) begin
         plane_in[p] = plane_ff[p];
         if (csr_write && (csr_idx == plane_idx_type'(p))) begin
            plane_in[p] = pwdata;
         end
         if (csr_idx == plane_idx_type'(p)) begin
            prdata = plane_ff[p];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
         if (reset) begin
            plane_ff[p] <= '0;
         end else begin
            plane_ff[p] <= plane_in[p];
         end
      end
   end

   // ------------------------------------------------------------------------------------
   // Input register. Every cycle out of reset may accept a transfer, so busy only reflects
   // reset. Planes must be written only while the pipeline is empty (the user's duty; the
   // block does not enforce it), so each stage may read the plane registers directly.
   // ------------------------------------------------------------------------------------
   logic                          s0_valid_ff, s0_valid_in;
   op_type                        s0_op_ff;
   logic signed [COORD_BITS-1:0]  s0_min_ff [3];
   logic signed [COORD_BITS-1:0]  s0_max_ff [3];

   assign busy        = reset;
   assign s0_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_valid_in) begin
         s0_op_ff     <= op_type'(req_operation);
         s0_min_ff[0] <= req_min_x;
         s0_min_ff[1] <= req_min_y;
         s0_min_ff[2] <= req_min_z;
         s0_max_ff[0] <= req_max_x;
         s0_max_ff[1] <= req_max_y;
         s0_max_ff[2] <= req_max_z;
      end
   end

   // ------------------------------------------------------------------------------------
   // Product stage. For a box, n*(min+max) + |n|*(max-min) collapses per axis to
   // 2*n*max when n is not negative and to 2*n*min when it is: the box corner that lies
   // farthest along the normal. The common factor of two, applied to the whole plane sum
   // (distance included), never changes the sign, so box mode uses the same sum as point
   // mode with that corner in place of the point. One multiplier per plane and axis.
   // ------------------------------------------------------------------------------------
   logic                          s1_valid_ff;
   logic signed [PROD_BITS-1:0]   prod_ff [NUM_PLANES][3];
   logic signed [PROD_BITS-1:0]   prod_in [NUM_PLANES][3];

   always_comb begin
      logic signed [NORMAL_BITS-1:0] nrm;
      logic signed [COORD_BITS-1:0]  corner;
      for (int p = 0; p < NUM_PLANES; p++) begin
         for (int a = 0; a < 3; a++) begin
            nrm = plane_ff[p][a*NORMAL_BITS +: NORMAL_BITS];
            if ((s0_op_ff == OP_POINT) || nrm[NORMAL_BITS-1]) begin
               corner = s0_min_ff[a];
            end else begin
               corner = s0_max_ff[a];
            end
            prod_in[p][a] = PROD_BITS'(nrm) * PROD_BITS'(corner);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_valid_ff) begin
         prod_ff <= prod_in;
      end
   end

   // ------------------------------------------------------------------------------------
   // Sum and compare stage. Each plane adds its three products and the aligned distance;
   // the item is rejected if any of the six sums is negative. All-zero planes give zero
   // sums, so everything is visible after reset.
   // ------------------------------------------------------------------------------------
   logic rsp_valid_ff,   rsp_valid_in;
   logic rsp_visible_ff, rsp_visible_in;

   always_comb begin
      logic [PACK_BITS-1:0]          packed_plane;
      logic signed [COORD_BITS-1:0]  plane_dist;
      logic signed [SUM_BITS-1:0]    plane_sum;
      rsp_visible_in = 1'b1;
      for (int p = 0; p < NUM_PLANES; p++) begin
         packed_plane = PACK_BITS'(plane_ff[p]);
         plane_dist   = packed_plane[DIST_LSB +: COORD_BITS];
         plane_sum    = SUM_BITS'(prod_ff[p][0]) + SUM_BITS'(prod_ff[p][1])
                      + SUM_BITS'(prod_ff[p][2]) + (SUM_BITS'(plane_dist) <<< NRM_FRAC);
         if (plane_sum[SUM_BITS-1]) begin
            rsp_visible_in = 1'b0;
         end
      end
   end

   assign rsp_valid_in = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rsp_visible_ff <= rsp_visible_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_visible = rsp_visible_ff;

endmodule

`default_nettype wire

@@ hdl/fbpc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "frustum_box_point_cull_macros.svh"

module fbpc_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                start,
   input wire logic                                busy,
   input wire logic                                rsp_valid,
   input wire logic                                psel,
   input wire logic                                penable,
   input wire logic                                pwrite,
   input wire logic [fbpc_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input wire logic [fbpc_pkg::CSR_DATA_BITS-1:0]  pwdata,
   input wire logic [fbpc_pkg::CSR_DATA_BITS-1:0]  prdata
);

   import fbpc_pkg::*;

   // Out of reset a transfer can be taken in every cycle.
   `FBPC_ASSERT_IMPLY(a_never_busy, clock, reset, 1'b1, !busy, "busy high outside reset")

   // Every accepted transfer that no reset follows yields a result.
   `FBPC_ASSERT_NEXT(a_result_follows, clock, reset, (start && !busy) ##1 !reset ##1 !reset, rsp_valid, "accepted item produced no result")

   // No result appears without an earlier accepted transfer.
   `FBPC_ASSERT_IMPLY(a_no_spurious, clock, reset, rsp_valid, $past(start && !busy, 3), "result without an accepted item")

   // A plane written and then read at the same address returns the written data.
   `FBPC_ASSERT_IMPLY(a_readback, clock, reset, (psel && penable && pwrite && (paddr[CSR_IDX_LSB +: PLANE_IDX_BITS] < NUM_PLANES)) ##1 (psel && !pwrite && (paddr == $past(paddr))), prdata == $past(pwdata), "plane register read-back mismatch")

endmodule

bind frustum_box_point_cull fbpc_checker u_fbpc_checker (.*);

`default_nettype wire
